### sv/brar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brar_pkg: shared types and constants
// Register map, opcodes and the configuration bundle of the button remap and
// auto-repeat unit.
// ----------------------------------------------------------------------------
package brar_pkg;

  localparam int REG_SLOTS  = 4;
  localparam int SLOT_W     = $clog2(REG_SLOTS);
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int BTN_W      = 32;
  localparam int TICK_W     = 64;
  localparam int COUNT_W    = 9;
  localparam int LIMIT_W    = 8;
  localparam int IN_TDATA_W = 136;

  localparam logic [BTN_W-1:0]   RESET_SLOW_DELAY = 32'd250000;
  localparam logic [BTN_W-1:0]   RESET_FAST_DELAY = 32'd100000;
  localparam logic [LIMIT_W-1:0] RESET_SLOW_LIMIT = 8'd1;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_SYNC   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    REG_REMAP_0     = 3'd0,
    REG_REMAP_1     = 3'd1,
    REG_REMAP_2     = 3'd2,
    REG_REMAP_3     = 3'd3,
    REG_SLOW_DELAY  = 3'd4,
    REG_FAST_DELAY  = 3'd5,
    REG_SLOW_LIMIT  = 3'd6,
    REG_REPEAT_MASK = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [REG_SLOTS-1:0][2*BTN_W-1:0] remap_entry;
    logic [BTN_W-1:0]                  slow_delay;
    logic [BTN_W-1:0]                  fast_delay;
    logic [LIMIT_W-1:0]                slow_limit;
    logic [BTN_W-1:0]                  repeat_mask;
  } cfg_t;

endpackage

### sv/button_remap_auto_repeat_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_remap_auto_repeat_unit: chord remap with two-speed auto repeat
// Input beats carry an opcode, raw buttons, extra direction bits and a
// 64-bit timestamp on in_tdata. Every input beat yields exactly one output
// beat on out_tdata with the reported buttons (zero for sync, clear and
// unused opcodes). Beats pass an input register, then remap and repeat
// logic, then an output register. While out_tready stays high, one beat
// per cycle is sustained; the repeat state is read and written as a beat
// moves from the input register to the output register.
// When out_tready is low, the output register holds its beat and one more
// beat waits in the input register; after that in_tready drops.
// Configuration goes through the APB-style port (64-bit data, register i at
// byte address 8*i). The user writes it only while no beat is in flight;
// the block itself does not enforce this. Synchronous reset empties both
// registers, zeroes the held pattern, hold time and repeat count, and loads
// the register defaults.
// ----------------------------------------------------------------------------
module button_remap_auto_repeat_unit #(
  parameter int REMAP_ENTRIES = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: opcode[1:0], raw_buttons[33:2], extra_buttons[65:34],
  // now_tick[129:66], zero fill[135:130].
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [brar_pkg::IN_TDATA_W-1:0]   in_tdata,
  // out_tdata: reported_buttons[31:0].
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [brar_pkg::BTN_W-1:0]        out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [brar_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [brar_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [brar_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import brar_pkg::*;

  cfg_t              cfg;
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [1:0]        s1_op_r;
  logic [BTN_W-1:0]  s1_raw_r;
  logic [BTN_W-1:0]  s1_extra_r;
  logic [TICK_W-1:0] s1_now_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [BTN_W-1:0]  out_data_r;
  logic [BTN_W-1:0]  remapped;
  logic [BTN_W-1:0]  result;
  logic              in_fire;
  logic              advance;
  logic              go;

  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || advance;
  assign in_fire    = in_tvalid && in_tready;
  assign go         = s1_valid_r && advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  brar_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  brar_remap #(
    .NUM_ENTRIES (REMAP_ENTRIES)
  ) u_remap (
    .cfg         (cfg),
    .raw_buttons (s1_raw_r),
    .remapped    (remapped)
  );

  brar_repeat_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (go),
    .opcode        (s1_op_r),
    .remapped      (remapped),
    .extra_buttons (s1_extra_r),
    .now_tick      (s1_now_r),
    .cfg           (cfg),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r    <= in_tdata[1:0];
      s1_raw_r   <= in_tdata[2 +: BTN_W];
      s1_extra_r <= in_tdata[2+BTN_W +: BTN_W];
      s1_now_r   <= in_tdata[2+2*BTN_W +: TICK_W];
    end
    if (go) begin
      out_data_r <= result;
    end
  end

endmodule

### sv/brar_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brar_cfg_regs: configuration register file
// APB-style write and read access to the chord entries and repeat settings.
// ----------------------------------------------------------------------------
module brar_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [brar_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [brar_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [brar_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output brar_pkg::cfg_t                  cfg
);
  import brar_pkg::*;

  cfg_t             cfg_r;
  cfg_t             cfg_nxt;
  reg_idx_t         reg_idx;
  logic [SLOT_W-1:0] slot;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
  assign slot    = paddr[3 +: SLOT_W];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx) inside
        REG_REMAP_0, REG_REMAP_1, REG_REMAP_2, REG_REMAP_3: begin
          cfg_nxt.remap_entry[slot] = pwdata;
        end
        REG_SLOW_DELAY:  cfg_nxt.slow_delay  = pwdata[BTN_W-1:0];
        REG_FAST_DELAY:  cfg_nxt.fast_delay  = pwdata[BTN_W-1:0];
        REG_SLOW_LIMIT:  cfg_nxt.slow_limit  = pwdata[LIMIT_W-1:0];
        REG_REPEAT_MASK: cfg_nxt.repeat_mask = pwdata[BTN_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx) inside
      REG_REMAP_0, REG_REMAP_1, REG_REMAP_2, REG_REMAP_3: begin
        prdata = cfg_r.remap_entry[slot];
      end
      REG_SLOW_DELAY:  prdata = {{(CFG_DATA_W-BTN_W){1'b0}}, cfg_r.slow_delay};
      REG_FAST_DELAY:  prdata = {{(CFG_DATA_W-BTN_W){1'b0}}, cfg_r.fast_delay};
      REG_SLOW_LIMIT:  prdata = {{(CFG_DATA_W-LIMIT_W){1'b0}}, cfg_r.slow_limit};
      REG_REPEAT_MASK: prdata = {{(CFG_DATA_W-BTN_W){1'b0}}, cfg_r.repeat_mask};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.remap_entry <= '0;
      cfg_r.slow_delay  <= RESET_SLOW_DELAY;
      cfg_r.fast_delay  <= RESET_FAST_DELAY;
      cfg_r.slow_limit  <= RESET_SLOW_LIMIT;
      cfg_r.repeat_mask <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### sv/brar_remap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brar_remap: chord remap
// Applies the chord entries to the raw button bits in parallel.
// ----------------------------------------------------------------------------
module brar_remap #(
  parameter int NUM_ENTRIES = 4
) (
  input  brar_pkg::cfg_t                 cfg,
  input  logic [brar_pkg::BTN_W-1:0]     raw_buttons,
  output logic [brar_pkg::BTN_W-1:0]     remapped
);
  import brar_pkg::*;

  logic [BTN_W-1:0] add_bits;
  logic [BTN_W-1:0] drop_bits;
  logic [BTN_W-1:0] real_bits;
  logic [BTN_W-1:0] alt_bits;

  always_comb begin
    add_bits  = '0;
    drop_bits = '0;
    real_bits = '0;
    alt_bits  = '0;
    for (int k = 0; k < REG_SLOTS; k++) begin
      real_bits = cfg.remap_entry[k][2*BTN_W-1:BTN_W];
      alt_bits  = cfg.remap_entry[k][BTN_W-1:0];
      if ((k < NUM_ENTRIES) && (|real_bits) && (|alt_bits)) begin
        drop_bits = drop_bits | alt_bits;
        if ((raw_buttons & real_bits) == real_bits) begin
          drop_bits = drop_bits | real_bits;
          add_bits  = add_bits | alt_bits;
        end
      end
    end
    remapped = (raw_buttons & ~drop_bits) | add_bits;
  end

endmodule

### sv/brar_repeat_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brar_repeat_core: held pattern and repeat timing
// Holds the pattern state and decides, per beat, what is reported.
// ----------------------------------------------------------------------------
module brar_repeat_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic [1:0]                   opcode,
  input  logic [brar_pkg::BTN_W-1:0]   remapped,
  input  logic [brar_pkg::BTN_W-1:0]   extra_buttons,
  input  logic [brar_pkg::TICK_W-1:0]  now_tick,
  input  brar_pkg::cfg_t               cfg,
  output logic [brar_pkg::BTN_W-1:0]   result
);
  import brar_pkg::*;

  logic [TICK_W-1:0]  held_since_r;
  logic [TICK_W-1:0]  held_since_nxt;
  logic [BTN_W-1:0]   held_pattern_r;
  logic [BTN_W-1:0]   held_pattern_nxt;
  logic [COUNT_W-1:0] repeat_count_r;
  logic [COUNT_W-1:0] repeat_count_nxt;
  logic [BTN_W-1:0]   pattern;
  logic [BTN_W-1:0]   delay;
  logic [TICK_W-1:0]  elapsed;
  logic [COUNT_W-1:0] limit_ext;
  logic               expired;
  logic               repeat_off;

  assign pattern    = remapped | extra_buttons;
  assign limit_ext  = {{(COUNT_W-LIMIT_W){1'b0}}, cfg.slow_limit};
  assign delay      = (repeat_count_r >= limit_ext) ? cfg.fast_delay : cfg.slow_delay;
  assign elapsed    = now_tick - held_since_r;
  assign expired    = (|elapsed[TICK_W-1:BTN_W]) || (elapsed[BTN_W-1:0] > delay);
  assign repeat_off = (cfg.slow_delay == '0) && (cfg.fast_delay == '0) &&
                      (cfg.slow_limit == '0);

  always_comb begin
    held_since_nxt   = held_since_r;
    held_pattern_nxt = held_pattern_r;
    repeat_count_nxt = repeat_count_r;
    result           = '0;
    case (opcode)
      OP_SAMPLE: begin
        if (pattern != '0) begin
          if (pattern == held_pattern_r) begin
            if (!repeat_off && expired) begin
              held_since_nxt = now_tick;
              if (repeat_count_r <= limit_ext) begin
                repeat_count_nxt = repeat_count_r + 1'b1;
              end
              result = pattern & cfg.repeat_mask;
            end
          end else begin
            held_since_nxt   = now_tick;
            held_pattern_nxt = pattern;
            repeat_count_nxt = '0;
            result           = pattern;
          end
        end
      end
      OP_SYNC: begin
        held_since_nxt   = now_tick;
        held_pattern_nxt = remapped;
        repeat_count_nxt = '0;
      end
      OP_CLEAR: begin
        held_since_nxt   = '0;
        held_pattern_nxt = '0;
        repeat_count_nxt = '0;
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_since_r   <= '0;
      held_pattern_r <= '0;
      repeat_count_r <= '0;
    end else if (go) begin
      held_since_r   <= held_since_nxt;
      held_pattern_r <= held_pattern_nxt;
      repeat_count_r <= repeat_count_nxt;
    end
  end

  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    go && (opcode == OP_CLEAR) |=>
      (held_pattern_r == '0) && (repeat_count_r == '0) && (held_since_r == '0))
    else $error("clear did not zero the repeat state");

  a_sync_state: assert property (@(posedge clk) disable iff (!rst_n)
    go && (opcode == OP_SYNC) |=>
      (held_since_r == $past(now_tick)) && (repeat_count_r == '0))
    else $error("sync did not restart the hold time");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> $stable(held_pattern_r) && $stable(repeat_count_r) && $stable(held_since_r))
    else $error("repeat state changed without a beat");

  a_no_report: assert property (@(posedge clk) disable iff (!rst_n)
    go && (opcode != OP_SAMPLE) |-> (result == '0))
    else $error("non-sample beat reported buttons");

  a_new_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    go && (opcode == OP_SAMPLE) && (pattern != '0) && (pattern != held_pattern_r) |->
      (result == pattern))
    else $error("new pattern not reported at once");

endmodule

### tb/button_remap_auto_repeat_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_remap_auto_repeat_unit_tb: self-checking bench for the repeat unit
// A queue of pad beats feeds a stream driver, and a monitor checks every
// result beat against a model of chord remap and two-speed auto repeat.
// Directed beats run first on reset settings; random phases then cover
// chord sets, disabled repeats, huge delays, count saturation and random
// settings, with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module button_remap_auto_repeat_unit_tb;
  import brar_pkg::*;

  localparam int REMAP_ENTRIES = 4;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int LONG_HOLD_CYCLES = 60;

  typedef struct packed {
    logic [TICK_W-1:0] now_tick;
    logic [BTN_W-1:0]  extra_buttons;
    logic [BTN_W-1:0]  raw_buttons;
    logic [1:0]        opcode;
  } pad_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [BTN_W-1:0]      out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  button_remap_auto_repeat_unit #(
    .REMAP_ENTRIES(REMAP_ENTRIES)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // Register shadows and repeat state of the model.
  logic [2*BTN_W-1:0] remap_cfg [REG_SLOTS] = '{default: '0};
  logic [BTN_W-1:0]   slow_delay_cfg = RESET_SLOW_DELAY;
  logic [BTN_W-1:0]   fast_delay_cfg = RESET_FAST_DELAY;
  logic [LIMIT_W-1:0] slow_limit_cfg = RESET_SLOW_LIMIT;
  logic [BTN_W-1:0]   repeat_mask_cfg = '0;
  logic [TICK_W-1:0]  held_since = '0;
  logic [BTN_W-1:0]   held_pattern = '0;
  logic [COUNT_W-1:0] repeat_count = '0;

  pad_beat_t        pending_beats [$];
  logic [BTN_W-1:0] expected_reports [$];
  pad_beat_t        cur_beat;
  logic [BTN_W-1:0] expected_now;
  bit               beat_live = 1'b0;
  bit               idle_on = 1'b1;
  bit               long_hold_req = 1'b0;
  int               send_gap = 0;
  int               stall_left = 0;
  int               hold_left = 0;
  int               error_count = 0;
  int               beats_accepted = 0;
  int               repeats_seen = 0;
  int               input_stalls = 0;
  int               settings_used = 1;

  // Stimulus generator state.
  logic [TICK_W-1:0] tick_now = '0;
  logic [BTN_W-1:0]  raw_pool [4];
  logic [BTN_W-1:0]  extra_pool = '0;
  logic [BTN_W-1:0]  held_raw = '0;
  logic [BTN_W-1:0]  held_extra = '0;

  function automatic logic [BTN_W-1:0] remap_buttons(input logic [BTN_W-1:0] raw);
    logic [BTN_W-1:0] add_bits, drop_bits, chord_keys, alt_keys;
    add_bits  = '0;
    drop_bits = '0;
    for (int k = 0; k < REMAP_ENTRIES && k < REG_SLOTS; k++) begin
      chord_keys = remap_cfg[k][2*BTN_W-1:BTN_W];
      alt_keys   = remap_cfg[k][BTN_W-1:0];
      if (chord_keys != '0 && alt_keys != '0) begin
        drop_bits |= alt_keys;
        if ((raw & chord_keys) == chord_keys) begin
          drop_bits |= chord_keys;
          add_bits  |= alt_keys;
        end
      end
    end
    return (raw & ~drop_bits) | add_bits;
  endfunction

  function automatic logic [BTN_W-1:0] predict_report(input pad_beat_t b);
    logic [BTN_W-1:0] pattern, delay;
    pattern = '0;
    case (b.opcode)
      OP_SAMPLE: begin
        pattern = remap_buttons(b.raw_buttons) | b.extra_buttons;
        delay = ({1'b0, slow_limit_cfg} <= repeat_count) ? fast_delay_cfg : slow_delay_cfg;
        if (pattern != '0) begin
          if (pattern == held_pattern) begin
            if (slow_delay_cfg == '0 && fast_delay_cfg == '0 && slow_limit_cfg == '0) begin
              pattern = '0;
            end else if (b.now_tick - held_since > {32'd0, delay}) begin
              held_since = b.now_tick;
              if (repeat_count <= {1'b0, slow_limit_cfg}) repeat_count = repeat_count + 1'b1;
              pattern &= repeat_mask_cfg;
              repeats_seen++;
            end else begin
              pattern = '0;
            end
          end else begin
            held_since   = b.now_tick;
            held_pattern = pattern;
            repeat_count = '0;
          end
        end
      end
      OP_SYNC: begin
        held_since   = b.now_tick;
        repeat_count = '0;
        held_pattern = remap_buttons(b.raw_buttons);
      end
      OP_CLEAR: begin
        held_since   = '0;
        repeat_count = '0;
        held_pattern = '0;
      end
      default: begin
      end
    endcase
    return pattern;
  endfunction

  // Input side: accept beats and predict; output side: check results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_tready) input_stalls++;
      if (in_tvalid && in_tready) begin
        expected_reports.push_back(predict_report(cur_beat));
        beat_live = 1'b0;
        beats_accepted++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_reports.size() == 0) begin
          error_count++;
          $display("%0t ns: result beat with none expected, expected nothing, got %h",
                   $time, out_tdata);
        end else begin
          expected_now = expected_reports.pop_front();
          if (out_tdata !== expected_now) begin
            error_count++;
            $display("%0t ns: reported_buttons mismatch, expected %h, got %h",
                     $time, expected_now, out_tdata);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && !beat_live) begin
      if (send_gap != 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        cur_beat = pending_beats.pop_front();
        beat_live = 1'b1;
        in_tdata <= IN_TDATA_W'(cur_beat);
        in_tvalid <= 1'b1;
        if (idle_on && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 5);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (idle_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 5);
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] readback;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_SLOW_DELAY: begin
        slow_delay_cfg = value[BTN_W-1:0];
        readback = {32'd0, slow_delay_cfg};
      end
      REG_FAST_DELAY: begin
        fast_delay_cfg = value[BTN_W-1:0];
        readback = {32'd0, fast_delay_cfg};
      end
      REG_SLOW_LIMIT: begin
        slow_limit_cfg = value[LIMIT_W-1:0];
        readback = {56'd0, slow_limit_cfg};
      end
      REG_REPEAT_MASK: begin
        repeat_mask_cfg = value[BTN_W-1:0];
        readback = {32'd0, repeat_mask_cfg};
      end
      default: begin
        remap_cfg[idx[SLOT_W-1:0]] = value;
        readback = value;
      end
    endcase
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== readback) begin
      error_count++;
      $display("%0t ns: register %0d read back, expected %h, got %h",
               $time, idx, readback, cfg_prdata);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_config(input logic [63:0] e0, input logic [63:0] e1,
                            input logic [63:0] e2, input logic [63:0] e3,
                            input logic [31:0] slow, input logic [31:0] fast,
                            input logic [7:0] limit, input logic [31:0] mask);
    write_reg(REG_REMAP_0, e0);
    write_reg(REG_REMAP_1, e1);
    write_reg(REG_REMAP_2, e2);
    write_reg(REG_REMAP_3, e3);
    write_reg(REG_SLOW_DELAY, {32'd0, slow});
    write_reg(REG_FAST_DELAY, {32'd0, fast});
    write_reg(REG_SLOW_LIMIT, {56'd0, limit});
    write_reg(REG_REPEAT_MASK, {32'd0, mask});
    settings_used++;
    for (int k = 0; k < REG_SLOTS; k++) begin
      raw_pool[k] = remap_cfg[k][2*BTN_W-1:BTN_W];
      if ($urandom_range(0, 1) == 1) raw_pool[k][5'($urandom_range(0, 31))] = 1'b1;
      if (raw_pool[k] == '0) raw_pool[k] = $urandom;
    end
    extra_pool = $urandom & $urandom & $urandom;
    held_raw   = raw_pool[0];
    held_extra = '0;
  endtask

  function automatic logic [63:0] make_chord(input int keys_n);
    logic [31:0] keys, alts;
    keys = '0;
    alts = '0;
    for (int i = 0; i < keys_n; i++) keys[5'($urandom_range(0, 31))] = 1'b1;
    alts[5'($urandom_range(0, 31))] = 1'b1;
    if ($urandom_range(0, 1) == 1) alts[5'($urandom_range(0, 31))] = 1'b1;
    return {keys, alts};
  endfunction

  task automatic push_beat(input logic [1:0] opcode, input logic [31:0] raw,
                           input logic [31:0] extra, input logic [63:0] now_tick);
    pad_beat_t b;
    b.opcode        = opcode;
    b.raw_buttons   = raw;
    b.extra_buttons = extra;
    b.now_tick      = now_tick;
    pending_beats.push_back(b);
  endtask

  // Mostly held patterns so that repeats fire; churn_pct sets how many
  // beats are syncs, clears, unused opcodes, noise, releases or new presses.
  task automatic queue_beats(input int count, input int churn_pct, input int step_lo,
                             input int step_hi, input int step_shift);
    int sub;
    logic [63:0] step;
    for (int n = 0; n < count; n++) begin
      step = 64'($urandom_range(step_lo, step_hi)) << step_shift;
      tick_now += step;
      if ($urandom_range(0, 99) == 0) tick_now = {$urandom, $urandom};
      if ($urandom_range(0, 99) < churn_pct) begin
        sub = $urandom_range(0, 5);
        case (sub)
          0: push_beat(OP_SYNC, raw_pool[2'($urandom_range(0, 3))], $urandom, tick_now);
          1: push_beat(OP_CLEAR, $urandom, $urandom, tick_now);
          2: push_beat(OP_UNUSED, $urandom, $urandom, tick_now);
          3: push_beat(OP_SAMPLE, $urandom, $urandom, tick_now);
          4: push_beat(OP_SAMPLE, '0, '0, tick_now);
          default: begin
            held_raw   = raw_pool[2'($urandom_range(0, 3))];
            held_extra = ($urandom_range(0, 2) == 0) ? extra_pool : '0;
            push_beat(OP_SAMPLE, held_raw, held_extra, tick_now);
          end
        endcase
      end else begin
        push_beat(OP_SAMPLE, held_raw, held_extra, tick_now);
      end
    end
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || beat_live || expected_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_beat(OP_SAMPLE, '0, '0, 64'd0);
    push_beat(OP_SAMPLE, 32'hFFFF_FFFF, '0, 64'd10);
    push_beat(OP_SAMPLE, 32'hFFFF_FFFF, '0, 64'd250010);
    push_beat(OP_SAMPLE, 32'hFFFF_FFFF, '0, 64'd250011);
    push_beat(OP_SAMPLE, '0, '0, 64'd300000);
    push_beat(OP_SAMPLE, 32'hFFFF_FFFF, '0, 64'd350011);
    push_beat(OP_SAMPLE, 32'hFFFF_FFFF, '0, 64'd350012);
    push_beat(OP_SAMPLE, 32'hFFFF_FFFF, '0, 64'd900000);
    push_beat(OP_SAMPLE, '0, 32'h0000_FFFF, 64'd900001);
    push_beat(OP_SYNC, 32'h0000_0005, 32'hFFFF_FFFF, 64'd900002);
    push_beat(OP_SAMPLE, 32'h0000_0005, '0, 64'd900003);
    push_beat(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
    push_beat(OP_SAMPLE, 32'h0000_0005, '0, 64'd2000000);
    push_beat(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
    push_beat(OP_SAMPLE, 32'h8000_0001, '0, 64'hFFFF_FFFF_FFFF_FFF0);
    push_beat(OP_SAMPLE, 32'h8000_0001, '0, 64'h0000_0000_0004_0000);
    push_beat(OP_SAMPLE, '0, 32'h8000_0000, 64'h0000_0000_0004_0001);
    push_beat(OP_SAMPLE, 32'h8000_0000, 32'h8000_0000, 64'h0000_0000_0008_0000);
    push_beat(OP_SYNC, '0, '0, '1);
    push_beat(OP_SAMPLE, '0, '0, '0);
    push_beat(OP_CLEAR, '0, '0, '0);
    push_beat(OP_SAMPLE, 32'h0000_0001, '0, 64'd1);
    drain();

    set_config(make_chord(2), make_chord(1), make_chord(3), make_chord(2),
               32'd40, 32'd10, 8'd2, $urandom);
    queue_beats(400, 30, 0, 20, 0);
    @(posedge clk);
    long_hold_req = 1'b1;
    drain();

    set_config(64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
               make_chord(1), 32'd0, 32'd0, 8'd0, 32'hFFFF_FFFF);
    queue_beats(250, 30, 0, 4, 0);
    drain();

    set_config(make_chord(1), make_chord(2), {$urandom, $urandom}, make_chord(4),
               32'hFFFF_FFFF, 32'd0, 8'hFF, 32'hFFFF_FFFF);
    queue_beats(250, 25, 0, 3, 31);
    drain();

    set_config(make_chord(2), '0, make_chord(1), '0, 32'd0, 32'd1, 8'hFF, $urandom);
    queue_beats(300, 0, 1, 2, 0);
    queue_beats(60, 40, 1, 2, 0);
    drain();

    repeat (3) begin
      set_config({$urandom, $urandom}, make_chord(2), {$urandom & $urandom, $urandom},
                 make_chord($urandom_range(1, 3)), $urandom_range(0, 60),
                 $urandom_range(0, 30), 8'($urandom_range(0, 4)), $urandom);
      queue_beats(150, 35, 0, 25, 0);
      drain();
    end

    idle_on = 1'b0;
    set_config(make_chord(1), make_chord(2), make_chord(1), make_chord(3),
               32'd8, 32'd3, 8'd1, 32'h0000_FFFF);
    queue_beats(200, 30, 0, 6, 0);
    drain();
    repeat (8) @(posedge clk);

    if (expected_reports.size() != 0) begin
      error_count++;
      $display("%0t ns: results still outstanding, expected 0, got %0d",
               $time, expected_reports.size());
    end
    $display("Run covered %0d input beats over %0d register settings.",
             beats_accepted, settings_used);
    $display("It saw %0d accepted repeats and %0d cycles of input backpressure.",
             repeats_seen, input_stalls);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t ns: run timed out", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
